[src/i2cmbe_pkg.sv]
// Package for the I2C master byte engine.
// Holds the payload structs, command codes, queue sizing and reset constants.
// No dependencies.
package i2cmbe_pkg;

    // Raw op codes on the input item
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Default width of the segment wait counter
    localparam int WAIT_WIDTH_DEF = 16;

    // Reset value of half_period
    localparam logic [15:0] HALF_PERIOD_RST = 16'd10;

    // Depth of the input and result queues
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Classified command, as decided by the front end
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    // One input item (one tick)
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] wr_byte;
        logic       send_nack;
        logic       sda_in;
    } t_in_item;

    // One result item (one tick)
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
    } t_out_item;

    // Item held in the front queue: tick payload plus its decoded command
    typedef struct packed {
        t_cmd     cmd;
        t_in_item item;
    } t_front_item;

    // Handshake between a queue and the engine
    typedef struct packed {
        logic valid;
        logic take;
    } t_hs;

endpackage

[src/i2cmbe_front.sv]
// Front end of the I2C master byte engine: accepts ticks, decodes the op
// and queues them for the engine. Depends on i2cmbe_pkg.
module i2cmbe_front
    import i2cmbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    input  logic        i_take,
    output logic        o_valid,
    output t_front_item o_item
);

    t_front_item        r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wptr;
    logic [QPTR_W-1:0]  n_rptr;
    logic [QCNT_W-1:0]  n_count;
    logic               wr_en;
    logic               rd_en;
    t_cmd               dec_cmd;

    // Op decode; codes without meaning become no command
    always_comb begin
        case (i_in_item.op)
            OP_START: dec_cmd = CMD_START;
            OP_STOP:  dec_cmd = CMD_STOP;
            OP_WRITE: dec_cmd = CMD_WRITE;
            OP_READ:  dec_cmd = CMD_READ;
            default:  dec_cmd = CMD_NONE;
        endcase
    end

    assign full    = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign wr_en   = push && !full;
    assign rd_en   = i_take && o_valid;

    // Pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= '{cmd: dec_cmd, item: i_in_item};
        end
    end

endmodule

[src/i2cmbe_core.sv]
// Bus engine of the I2C master byte engine: runs the segment sequencer for
// one tick per queued item and builds its result. Depends on i2cmbe_pkg.
module i2cmbe_core
    import i2cmbe_pkg::*;
#(
    parameter int WAIT_WIDTH = WAIT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic        i_fire,
    input  t_front_item i_item,
    output t_out_item   o_result
);

    // Segment index within a command, one-hot
    typedef enum logic [6:0] {
        P_IDLE = 7'b0000001,
        P_1    = 7'b0000010,
        P_2    = 7'b0000100,
        P_3    = 7'b0001000,
        P_4    = 7'b0010000,
        P_5    = 7'b0100000,
        P_6    = 7'b1000000
    } t_phase;

    localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_WIDTH) - 33'd1;

    logic [15:0]           r_half;
    t_phase                r_phase;
    t_phase                n_phase;
    t_cmd                  r_op;
    t_cmd                  n_op;
    logic [3:0]            r_bc;
    logic [3:0]            n_bc;
    logic [WAIT_WIDTH-1:0] r_wait;
    logic [WAIT_WIDTH-1:0] n_wait;
    logic [7:0]            r_shift;
    logic [7:0]            n_shift;
    logic                  r_scl;
    logic                  n_scl;
    logic                  r_sda;
    logic                  n_sda;
    logic                  r_ack;
    logic                  n_ack;
    logic                  r_nack;
    logic                  n_nack;
    logic [7:0]            r_rx;
    logic [7:0]            n_rx;
    logic [32:0]           hp_wide;
    logic [32:0]           hp_clip;
    logic [WAIT_WIDTH-1:0] hp_sat;
    logic                  start_cmd;
    logic                  fin;
    logic                  busy;
    logic                  scl_out;
    logic                  sda_out;

    // SCL/SDA levels of a segment: {scl, sda}
    function automatic logic [1:0] seg_lv(t_cmd op, t_phase p, logic msb, logic nk);
        logic c;
        logic d;
        c = 1'b0;
        d = 1'b1;
        case (op)
            CMD_START: begin
                c = (p == P_1) || (p == P_2);
                d = (p == P_1);
            end
            CMD_STOP: begin
                c = (p != P_1);
                d = (p == P_3);
            end
            CMD_WRITE: begin
                c = (p == P_2) || (p == P_4);
                d = ((p == P_1) || (p == P_2)) ? msb : 1'b1;
            end
            CMD_READ: begin
                c = (p == P_2) || (p == P_5);
                d = ((p == P_4) || (p == P_5) || (p == P_6)) ? nk : 1'b1;
            end
            default: begin
                c = 1'b0;
                d = 1'b1;
            end
        endcase
        return {c, d};
    endfunction

    // Segment length: clip to the counter range, zero counts as one tick
    assign hp_wide = 33'(r_half);
    assign hp_clip = (hp_wide > WAIT_MAX) ? WAIT_MAX : hp_wide;
    assign hp_sat  = (hp_clip == '0) ? WAIT_WIDTH'(1) : hp_clip[WAIT_WIDTH-1:0];

    assign start_cmd = (r_phase == P_IDLE) && (i_item.cmd != CMD_NONE);

    // One tick of the sequencer
    always_comb begin
        n_phase = r_phase;
        n_op    = r_op;
        n_bc    = r_bc;
        n_wait  = r_wait;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_nack  = r_nack;
        n_rx    = r_rx;
        fin     = 1'b0;

        // command launch: first segment starts on this tick
        if (start_cmd) begin
            n_op    = i_item.cmd;
            n_phase = P_1;
            n_bc    = '0;
            if (i_item.cmd == CMD_WRITE) begin
                n_shift = i_item.item.wr_byte;
            end
            if (i_item.cmd == CMD_READ) begin
                n_shift = '0;
                n_nack  = i_item.item.send_nack;
            end
            {n_scl, n_sda} = seg_lv(n_op, n_phase, n_shift[7], n_nack);
            n_wait = hp_sat;
        end

        scl_out = n_scl;
        sda_out = n_sda;
        busy    = (n_phase != P_IDLE);

        // count down; at zero the segment ends
        if (busy) begin
            n_wait = n_wait - 1'b1;
            if (n_wait == '0) begin
                case (n_op)
                    CMD_START, CMD_STOP: begin
                        if (n_phase == P_3) begin
                            fin = 1'b1;
                        end else begin
                            n_phase = t_phase'({n_phase[5:0], 1'b0});
                        end
                    end
                    CMD_WRITE: begin
                        if (n_phase == P_2) begin
                            n_shift = {n_shift[6:0], 1'b0};
                            n_bc    = n_bc + 1'b1;
                            n_phase = (n_bc >= 4'd8) ? P_3 : P_1;
                        end else begin
                            if (n_phase == P_4) begin
                                n_ack = i_item.item.sda_in;
                            end
                            if (n_phase == P_5) begin
                                fin = 1'b1;
                            end else begin
                                n_phase = t_phase'({n_phase[5:0], 1'b0});
                            end
                        end
                    end
                    CMD_READ: begin
                        if (n_phase == P_2) begin
                            n_shift = {n_shift[6:0], i_item.item.sda_in};
                            n_bc    = n_bc + 1'b1;
                            n_phase = P_3;
                        end else if (n_phase == P_3) begin
                            n_phase = (n_bc >= 4'd8) ? P_4 : P_2;
                        end else if (n_phase == P_6) begin
                            n_rx = n_shift;
                            fin  = 1'b1;
                        end else begin
                            n_phase = t_phase'({n_phase[5:0], 1'b0});
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
                if (fin) begin
                    n_phase = P_IDLE;
                end else begin
                    {n_scl, n_sda} = seg_lv(n_op, n_phase, n_shift[7], n_nack);
                    n_wait = hp_sat;
                end
            end
        end
    end

    // Result of this tick
    always_comb begin
        o_result.scl_level   = scl_out;
        o_result.sda_release = sda_out;
        o_result.busy_res    = busy;
        o_result.done_res    = fin;
        o_result.rx_byte     = n_rx;
        o_result.ack_bit     = n_ack;
    end

    // Engine state, advanced only when a tick is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_op    <= CMD_NONE;
            r_bc    <= '0;
            r_wait  <= '0;
            r_shift <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
            r_nack  <= 1'b0;
            r_rx    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_bc    <= n_bc;
            r_wait  <= n_wait;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_nack  <= n_nack;
            r_rx    <= n_rx;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_PERIOD_RST;
        end else if (i_cfg_valid) begin
            r_half <= i_cfg_data;
        end
    end

    // A running command always has ticks left in its segment
    a_wait_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != P_IDLE) |-> (r_wait != '0))
        else $error("wait counter empty while busy");

    // Bit counter never passes the byte length
    a_bc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc <= 4'd8)
        else $error("bit counter out of range");

    // Dropping out of a command only happens with a done pulse
    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (r_phase != P_IDLE) && (n_phase == P_IDLE)) |-> o_result.done_res)
        else $error("command ended without done");

    // A processed tick while idle that launches nothing leaves the bus unchanged
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (r_phase == P_IDLE) && (i_item.cmd == CMD_NONE))
        |=> ($stable(r_scl) && $stable(r_sda) && (r_phase == P_IDLE)))
        else $error("idle tick changed bus levels");

endmodule

[src/i2cmbe_rq.sv]
// Result queue of the I2C master byte engine: holds finished result items
// until the receiver pops them. Depends on i2cmbe_pkg.
module i2cmbe_rq
    import i2cmbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_data
);

    t_out_item          r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wptr;
    logic [QPTR_W-1:0]  n_rptr;
    logic [QCNT_W-1:0]  n_count;
    logic               wr_en;
    logic               rd_en;

    assign o_full = (r_count == QCNT_W'(QDEPTH));
    assign empty  = (r_count == '0);
    assign o_data = r_mem[r_rptr];
    assign wr_en  = i_push && !o_full;
    assign rd_en  = pop && !empty;

    // Pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[src/i2c_master_byte_engine.sv]
// I2C master byte engine, top level.
// Usage:
//   Input channel (push/full): one transaction is one tick of the bus
//   engine. It carries the sampled SDA level and, when the engine is idle,
//   a command: start, stop, write byte, or read byte with ACK/NACK.
//   Result channel (empty/pop): exactly one result per tick, in order,
//   with the SCL/SDA levels to drive, busy, a one-tick done pulse, the
//   last received byte and the last write's ACK bit.
//   Configuration channel (valid/ready): half_period, ticks per segment;
//   ready is always high, write it only while the engine is idle.
// Timing:
//   A tick's result shows on the result ports after the engine takes it from
//   the input queue and writes its result into the result queue. The engine
//   processes one tick per clock while a tick is queued and a result slot is
//   free, so throughput is one transaction per cycle; the sequencer step is combinational.
// Reset: queues empty, engine idle, SCL and SDA released high,
//   half_period 10, rx_byte and ack_bit zero.
// Stall: when pop stays low the result queue fills, the engine holds its
//   state, then the input queue fills and full rises. No tick is lost.
module i2c_master_byte_engine
    import i2cmbe_pkg::*;
#(
    parameter int WAIT_WIDTH = WAIT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_hs         front_hs;
    t_front_item front_item;
    t_out_item   core_result;
    logic        rq_full;

    assign o_cfg_ready    = 1'b1;

    // Engine advances when a tick is queued and a result slot is free
    assign front_hs.take  = front_hs.valid && !rq_full;

    i2cmbe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_take    (front_hs.take),
        .o_valid   (front_hs.valid),
        .o_item    (front_item)
    );

    i2cmbe_core #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (front_hs.take),
        .i_item      (front_item),
        .o_result    (core_result)
    );

    i2cmbe_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_hs.take),
        .i_data  (core_result),
        .o_full  (rq_full),
        .pop     (pop),
        .empty   (empty),
        .o_data  (o_result)
    );

endmodule

[sim/i2c_master_byte_engine_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the I2C master byte engine (one transaction per bus tick).
// Depends on src/i2cmbe_pkg.sv and src/i2c_master_byte_engine.sv; predicts every tick internally.
module i2c_master_byte_engine_test;
    import i2cmbe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LINES   = 50;
    localparam int DRAIN_CYCLES   = 8;

    // sda_in patterns for the ticks of one command
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    localparam logic [3:0] PH_IDLE = 4'd0;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    t_in_item    in_item   = '0;
    logic        empty;
    logic        pop       = 1'b0;
    t_out_item   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // Engine image: bus levels and counters as the block should hold them
    logic [15:0] half_period_now = HALF_PERIOD_RST;
    logic [3:0]  m_phase = PH_IDLE;
    logic [3:0]  m_bits  = '0;
    logic [15:0] m_wait  = '0;
    logic [7:0]  m_shift = '0;
    logic [7:0]  m_rx    = '0;
    logic [2:0]  m_op    = OP_NONE;
    logic        m_scl   = 1'b1;
    logic        m_sda   = 1'b1;
    logic        m_ack   = 1'b0;
    logic        m_nack  = 1'b0;

    t_out_item   pending_ticks[$];
    int          ticks_sent     = 0;
    int          ticks_checked  = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          pop_hold       = 0;
    bit          quiet_run      = 1'b0;

    i2c_master_byte_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Segment levels: start (1,1)(1,0)(0,0); stop (0,0)(1,0)(1,1);
    // write bits (0,b)(1,b) then ack (0,1)(1,1)(0,1);
    // read (0,1) bits (1,1)(0,1) then (0,n)(1,n)(0,n)
    function automatic void load_segment();
        m_wait = (half_period_now == 16'd0) ? 16'd1 : half_period_now;
        m_scl  = 1'b0;
        m_sda  = 1'b1;
        case (m_op)
            OP_START: begin
                m_scl = (m_phase <= 4'd2);
                m_sda = (m_phase == 4'd1);
            end
            OP_STOP: begin
                m_scl = (m_phase >= 4'd2);
                m_sda = (m_phase == 4'd3);
            end
            OP_WRITE: begin
                m_scl = (m_phase == 4'd2 || m_phase == 4'd4);
                m_sda = (m_phase <= 4'd2) ? m_shift[7] : 1'b1;
            end
            OP_READ: begin
                m_scl = (m_phase == 4'd2 || m_phase == 4'd5);
                m_sda = (m_phase >= 4'd4) ? m_nack : 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Close the current segment; 1 when the command is complete
    function automatic bit end_segment(input logic sda);
        case (m_op)
            OP_START, OP_STOP: begin
                if (m_phase >= 4'd3) return 1'b1;
                m_phase++;
            end
            OP_WRITE: begin
                if (m_phase == 4'd2) begin
                    m_shift = m_shift << 1;
                    m_bits++;
                    m_phase = (m_bits >= 4'd8) ? 4'd3 : 4'd1;
                end else begin
                    // ack sampled at the end of the high half of the acknowledge clock
                    if (m_phase == 4'd4) m_ack = sda;
                    if (m_phase >= 4'd5) return 1'b1;
                    m_phase++;
                end
            end
            OP_READ: begin
                if (m_phase == 4'd2) begin
                    m_shift = {m_shift[6:0], sda};
                    m_bits++;
                    m_phase = 4'd3;
                end else if (m_phase == 4'd3) begin
                    m_phase = (m_bits >= 4'd8) ? 4'd4 : 4'd2;
                end else if (m_phase >= 4'd6) begin
                    m_rx = m_shift;
                    return 1'b1;
                end else begin
                    m_phase++;
                end
            end
            default: return 1'b1;
        endcase
        return 1'b0;
    endfunction

    // Advance the engine image by one tick and return the bus levels of that tick
    function automatic t_out_item engine_tick(input t_in_item it);
        t_out_item r;
        r = '0;
        if (m_phase == PH_IDLE && it.op >= OP_START && it.op <= OP_READ) begin
            m_op    = it.op;
            m_phase = 4'd1;
            m_bits  = '0;
            if (it.op == OP_WRITE) m_shift = it.wr_byte;
            if (it.op == OP_READ) begin
                m_shift = '0;
                m_nack  = it.send_nack;
            end
            load_segment();
        end
        r.scl_level   = m_scl;
        r.sda_release = m_sda;
        if (m_phase != PH_IDLE) begin
            r.busy_res = 1'b1;
            m_wait--;
            if (m_wait == 16'd0) begin
                if (end_segment(it.sda_in)) begin
                    m_phase    = PH_IDLE;
                    r.done_res = 1'b1;
                end else begin
                    load_segment();
                end
            end
        end
        r.rx_byte = m_rx;
        r.ack_bit = m_ack;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < REPORT_LINES)
            $display("mismatch at tick %0d: %s got %0h want %0h",
                     ticks_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_tick(input t_out_item got);
        t_out_item want;
        if (pending_ticks.size() == 0) begin
            report_mismatch("unexpected result", int'(got), 0);
        end else begin
            want = pending_ticks.pop_front();
            if (got.scl_level !== want.scl_level)
                report_mismatch("scl_level", int'(got.scl_level), int'(want.scl_level));
            if (got.sda_release !== want.sda_release)
                report_mismatch("sda_release", int'(got.sda_release),
                                int'(want.sda_release));
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
            if (got.rx_byte !== want.rx_byte)
                report_mismatch("rx_byte", int'(got.rx_byte), int'(want.rx_byte));
            if (got.ack_bit !== want.ack_bit)
                report_mismatch("ack_bit", int'(got.ack_bit), int'(want.ack_bit));
        end
        ticks_checked++;
    endtask

    // Result side: check each popped transaction, stall pop in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_tick(result);
            if (pop_hold > 0) begin
                pop_hold--;
                pop <= 1'b0;
            end else if (!quiet_run && $urandom_range(0, 19) == 0) begin
                pop_hold = $urandom_range(1, 18) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Send one tick; returns at the edge that accepted it, push left high
    task automatic send_tick(input t_in_item it);
        if (!quiet_run && $urandom_range(0, 15) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_ticks.push_back(engine_tick(it));
        ticks_sent++;
    endtask

    // Stop sending until every predicted tick has been popped
    task automatic pause_for_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_ticks.size() != 0);
    endtask

    function automatic t_in_item random_tick(input logic [2:0] op, input int sda_sel);
        t_in_item it;
        it.op        = op;
        it.wr_byte   = 8'($urandom_range(0, 255));
        it.send_nack = 1'($urandom_range(0, 1));
        case (sda_sel)
            SDA_LOW:  it.sda_in = 1'b0;
            SDA_HIGH: it.sda_in = 1'b1;
            default:  it.sda_in = 1'($urandom_range(0, 1));
        endcase
        return it;
    endfunction

    // Feed ticks until the running command completes; noisy ticks carry stray ops
    task automatic finish_command(input int sda_sel, input bit noisy);
        logic [2:0] op;
        while (m_phase != PH_IDLE) begin
            op = OP_NONE;
            if (noisy && $urandom_range(0, 7) == 0) op = 3'($urandom_range(0, 7));
            send_tick(random_tick(op, sda_sel));
            if (noisy && $urandom_range(0, 299) == 0) pause_for_results();
        end
    endtask

    task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                               input logic nack, input int sda_sel, input bit noisy);
        t_in_item it;
        it           = random_tick(op, sda_sel);
        it.wr_byte   = data;
        it.send_nack = nack;
        send_tick(it);
        finish_command(sda_sel, noisy);
    endtask

    // Register write, only with the engine idle and the queues drained
    task automatic set_half_period(input logic [15:0] value);
        pause_for_results();
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid       <= 1'b0;
        half_period_now  = value;
    endtask

    // Idle levels after reset, unknown ops ignored, then a start at the reset half period
    task automatic test_idle_after_reset();
        send_tick(random_tick(OP_NONE, SDA_LOW));
        send_tick(random_tick(OP_NONE, SDA_HIGH));
        send_tick(random_tick(3'd5, SDA_RANDOM));
        send_tick(random_tick(3'd6, SDA_RANDOM));
        send_tick(random_tick(3'd7, SDA_RANDOM));
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    endtask

    // Zero half period runs as one tick per segment
    task automatic test_zero_half_period();
        set_half_period(16'd0);
        run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    endtask

    task automatic test_start_stop();
        set_half_period(16'd1);
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
        run_command(OP_STOP, 8'hff, 1'b1, SDA_RANDOM, 1'b0);
    endtask

    // Byte extremes with ACK and NACK from the target
    task automatic test_write_byte();
        run_command(OP_WRITE, 8'hff, 1'b0, SDA_LOW, 1'b0);
        run_command(OP_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0);
        run_command(OP_WRITE, 8'ha5, 1'b0, SDA_RANDOM, 1'b0);
    endtask

    // All-ones read with NACK, all-zeros read with ACK
    task automatic test_read_byte();
        run_command(OP_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
        run_command(OP_READ, 8'hff, 1'b0, SDA_LOW, 1'b0);
        run_command(OP_READ, 8'h5a, 1'b1, SDA_RANDOM, 1'b0);
    endtask

    // Commands while busy and on the done tick are dropped; sender also drains mid-command
    task automatic test_ignored_commands();
        send_tick(random_tick(OP_START, SDA_RANDOM));
        send_tick(random_tick(OP_READ, SDA_RANDOM));
        send_tick(random_tick(OP_WRITE, SDA_RANDOM));
        run_command(OP_WRITE, 8'h3c, 1'b0, SDA_RANDOM, 1'b0);
        send_tick(random_tick(OP_READ, SDA_RANDOM));
        pause_for_results();
        send_tick(random_tick(OP_STOP, SDA_RANDOM));
        finish_command(SDA_RANDOM, 1'b1);
    endtask

    // Mostly whole commands with random content, some stray ticks
    task automatic test_random_traffic(input int n_ticks);
        int first;
        int sel;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks) begin
            sel = $urandom_range(0, 3);
            if (sel > SDA_RANDOM) sel = SDA_RANDOM;
            if ($urandom_range(0, 9) == 0) begin
                send_tick(random_tick(3'($urandom_range(0, 7)), sel));
                finish_command(sel, 1'b1);
            end else begin
                run_command(3'($urandom_range(OP_START, OP_READ)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), sel, 1'b1);
            end
        end
    endtask

    // Longer half period: one start condition spread over many ticks
    task automatic test_long_half_period();
        set_half_period(16'd16);
        run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_zero_half_period();
        test_start_stop();
        test_write_byte();
        test_read_byte();
        test_ignored_commands();

        set_half_period(16'd1);
        test_random_traffic(150);
        set_half_period(16'd2);
        test_random_traffic(150);
        set_half_period(16'($urandom_range(1, 4)));
        test_random_traffic(150);
        set_half_period(16'd3);
        test_random_traffic(150);

        // closing stretch runs without idling on either side
        pause_for_results();
        quiet_run = 1'b1;
        set_half_period(16'($urandom_range(1, 5)));
        test_random_traffic(150);
        test_long_half_period();

        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_ticks.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[i2c_master_byte_engine.f]
src/i2cmbe_pkg.sv
src/i2cmbe_front.sv
src/i2cmbe_core.sv
src/i2cmbe_rq.sv
src/i2c_master_byte_engine.sv
sim/i2c_master_byte_engine_test.sv
